// ----- hdl/bdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared opcodes, status codes, port widths and the controller command word
// for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;

  localparam logic [OPCODE_W-1:0] OP_PUSH_REAR  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_REAR   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Latch the incoming word.
    logic execute;  // Update pointers, count and the slot store.
    logic fetch;    // Read the front and rear slots.
    logic respond;  // Present the result for one cycle.
  } dp_cmd_t;

endpackage

// ----- hdl/bdq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer that walks each accepted word through execute, fetch and respond.
// ----------------------------------------------------------------------------
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output dp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_EXEC;
      S_EXEC:  state_next = S_FETCH;
      S_FETCH: state_next = S_RESP;
      S_RESP:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy        = (state != S_IDLE);
  assign cmd.capture = (state == S_IDLE) && start;
  assign cmd.execute = (state == S_EXEC);
  assign cmd.fetch   = (state == S_FETCH);
  assign cmd.respond = (state == S_RESP);

endmodule

// ----- hdl/bdq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_datapath
// Ring store with head and tail pointers, fill count and result registers.
// ----------------------------------------------------------------------------
module bdq_datapath
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dp_cmd_t                    cmd,
  input  logic        [OPCODE_W-1:0] opcode,
  input  logic signed [VALUE_W-1:0]  value,
  output logic                       done,
  output logic        [STATUS_W-1:0] status,
  output logic                       is_empty,
  output logic        [COUNT_W-1:0]  entry_count,
  output logic signed [VALUE_W-1:0]  front_value,
  output logic signed [VALUE_W-1:0]  rear_value
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [OPCODE_W-1:0]   op_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [PTR_W-1:0]      head;
  logic [PTR_W-1:0]      tail;
  logic [CNT_W-1:0]      count;
  logic [STATUS_W-1:0]   status_q;
  logic [DATA_WIDTH-1:0] rd_front;
  logic [DATA_WIDTH-1:0] rd_rear;

  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] head_dec;
  logic [PTR_W-1:0] tail_inc;
  logic [PTR_W-1:0] tail_dec;
  logic             is_full;
  logic             no_entries;
  logic [63:0]      val_wide;
  logic [63:0]      front_wide;
  logic [63:0]      rear_wide;

  assign head_inc   = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign head_dec   = (head == '0) ? LAST_IDX : head - 1'b1;
  assign tail_inc   = (tail == LAST_IDX) ? '0 : tail + 1'b1;
  assign tail_dec   = (tail == '0) ? LAST_IDX : tail - 1'b1;
  assign is_full    = (count == FULL_CNT);
  assign no_entries = (count == '0);
  assign val_wide   = {32'd0, value};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= opcode;
      val_q <= val_wide[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      status_q <= ST_OK;
    end else if (cmd.execute) begin
      status_q <= ST_OK;
      case (op_q)
        OP_PUSH_REAR: begin
          if (is_full) begin
            status_q <= ST_OVERFLOW;
          end else begin
            tail  <= tail_inc;
            count <= count + 1'b1;
          end
        end
        OP_PUSH_FRONT: begin
          if (is_full) begin
            status_q <= ST_OVERFLOW;
          end else begin
            head  <= head_dec;
            count <= count + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (no_entries) begin
            status_q <= ST_UNDERFLOW;
          end else begin
            head  <= head_inc;
            count <= count - 1'b1;
          end
        end
        default: begin
          if (no_entries) begin
            status_q <= ST_UNDERFLOW;
          end else begin
            tail  <= tail_dec;
            count <= count - 1'b1;
          end
        end
      endcase
    end
  end

  // Slot store: one write during execute, two reads during fetch.
  always_ff @(posedge clk) begin
    if (cmd.execute && !is_full) begin
      if (op_q == OP_PUSH_REAR) begin
        mem[tail] <= val_q;
      end else if (op_q == OP_PUSH_FRONT) begin
        mem[head_dec] <= val_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rd_front <= mem[head];
      rd_rear  <= mem[tail_dec];
    end
  end

  assign front_wide = 64'(rd_front);
  assign rear_wide  = 64'(rd_rear);

  assign done        = cmd.respond;
  assign status      = status_q;
  assign is_empty    = no_entries;
  assign entry_count = COUNT_W'(count);
  assign front_value = no_entries ? '0 : front_wide[VALUE_W-1:0];
  assign rear_value  = no_entries ? '0 : rear_wide[VALUE_W-1:0];

endmodule

// ----- hdl/bounded_double_ended_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Double-ended queue of signed words held in a bounded ring store.
// ----------------------------------------------------------------------------
// Usage: drive opcode and value and raise start. A word is taken at the rising
// edge where start is high and busy is low. The opcode selects push at the
// rear, push at the front, pop at the front or pop at the rear; pops ignore
// value. A push into a full queue or a pop of an empty one leaves the queue
// as it was and reports overflow or underflow.
// The result is driven onto the result ports once the word has passed the
// execute and fetch states and held there for exactly one cycle, marked by
// done, so it is taken at the edge that ends that cycle. It gives the status,
// the empty flag, the entry count and the front and rear words after the
// operation; the front and rear words read zero when the queue is empty.
// Busy stays high from the accepting edge until the respond state ends, so a
// new word is not taken before the last is through. The controller's
// four-state sequence runs execute to update the pointers, count and slot,
// fetch for the registered read of the front and rear slots from the ring
// memory, respond to present the result, and idle, in which the next word is taken.
// The receiver cannot stall the block; done is a strobe, not a handshake.
// Reset empties the queue at once; the slot contents are not cleared, since
// only live slots are ever shown.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic        [OPCODE_W-1:0] opcode,
  input  logic signed [VALUE_W-1:0]  value,
  output logic                       done,
  output logic        [STATUS_W-1:0] status,
  output logic                       is_empty,
  output logic        [COUNT_W-1:0]  entry_count,
  output logic signed [VALUE_W-1:0]  front_value,
  output logic signed [VALUE_W-1:0]  rear_value
);

  // Commands from the sequencer to the datapath.
  dp_cmd_t cmd;

  bdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath owns the ring store, pointers and result registers.
  bdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .opcode      (opcode),
    .value       (value),
    .done        (done),
    .status      (status),
    .is_empty    (is_empty),
    .entry_count (entry_count),
    .front_value (front_value),
    .rear_value  (rear_value)
  );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the bounded double-ended queue.
// ----------------------------------------------------------------------------
// Words go in through the start/busy handshake. Each accepted word is run
// through a local ring-buffer model, and the status, empty flag, count and
// front and rear words it predicts are queued. Every done strobe is checked
// against the oldest queued prediction. Directed tests cover the empty and
// full corners and the value extremes. A long random phase follows, made of
// bursts that lean toward filling, draining or mixed traffic, with random
// idle gaps on the send side.
// ----------------------------------------------------------------------------
module tb_top;
  import bdq_pkg::*;

  // The block is built with its default sizes, so the model mirrors them.
  localparam int RING_DEPTH   = 16;
  localparam int RANDOM_WORDS = 1850;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic        [OPCODE_W-1:0] opcode = OP_PUSH_REAR;
  logic signed [VALUE_W-1:0]  value = '0;
  logic                       busy;
  logic                       done;
  logic        [STATUS_W-1:0] status;
  logic                       is_empty;
  logic        [COUNT_W-1:0]  entry_count;
  logic signed [VALUE_W-1:0]  front_value;
  logic signed [VALUE_W-1:0]  rear_value;

  // One predicted result, laid out like the result ports.
  typedef struct {
    logic        [STATUS_W-1:0] status;
    logic                       is_empty;
    logic        [COUNT_W-1:0]  entry_count;
    logic signed [VALUE_W-1:0]  front_value;
    logic signed [VALUE_W-1:0]  rear_value;
  } deque_result_t;

  // Local copy of the queue: a 16-slot ring with 4-bit pointers that wrap on
  // their own, plus the fill level. The tail points one past the rear entry.
  logic signed [VALUE_W-1:0] ring_slots [RING_DEPTH];
  logic        [3:0]         ring_head = '0;
  logic        [3:0]         ring_tail = '0;
  logic        [COUNT_W-1:0] ring_fill = '0;

  deque_result_t pending_results [$];
  deque_result_t oldest_result;
  int            mismatch_count = 0;

  bounded_double_ended_queue dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .value      (value),
    .done       (done),
    .status     (status),
    .is_empty   (is_empty),
    .entry_count(entry_count),
    .front_value(front_value),
    .rear_value (rear_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one operation to the local ring and returns the result the block
  // should report for it. Overflow and underflow leave the ring untouched.
  function automatic deque_result_t apply_deque_op(input logic [OPCODE_W-1:0] op,
                                                   input logic signed [VALUE_W-1:0] val);
    deque_result_t r;
    logic [3:0]    rear_slot;
    r.status = ST_OK;
    case (op)
      OP_PUSH_REAR: begin
        if (ring_fill == RING_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          ring_slots[ring_tail] = val;
          ring_tail = ring_tail + 4'd1;
          ring_fill = ring_fill + 5'd1;
        end
      end
      OP_PUSH_FRONT: begin
        // The head steps back first, so a push into an empty ring lands in
        // the slot just before the tail and is both front and rear.
        if (ring_fill == RING_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          ring_head = ring_head - 4'd1;
          ring_slots[ring_head] = val;
          ring_fill = ring_fill + 5'd1;
        end
      end
      OP_POP_FRONT: begin
        if (ring_fill == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          ring_head = ring_head + 4'd1;
          ring_fill = ring_fill - 5'd1;
        end
      end
      default: begin
        if (ring_fill == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          ring_tail = ring_tail - 4'd1;
          ring_fill = ring_fill - 5'd1;
        end
      end
    endcase
    rear_slot     = ring_tail - 4'd1;
    r.is_empty    = (ring_fill == 0);
    r.entry_count = ring_fill;
    // An empty queue shows zero on both value ports, never a stale slot.
    r.front_value = (ring_fill == 0) ? '0 : ring_slots[ring_head];
    r.rear_value  = (ring_fill == 0) ? '0 : ring_slots[rear_slot];
    return r;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one. The short gaps
  // end at different points of the block's busy turn.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    else if (roll < 90) return $urandom_range(1, 3);
    else if (roll < 98) return $urandom_range(4, 10);
    else return $urandom_range(20, 50);
  endfunction

  // Values lean toward the signed extremes, zero and minus one, so the sign
  // bit and the all-ones pattern show up often on the value ports.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 32'sh7fff_ffff;
    else if (roll < 20) return 32'sh8000_0000;
    else if (roll < 25) return '0;
    else if (roll < 30) return -32'sd1;
    else if (roll < 45) return $urandom_range(0, 255);
    else return $urandom;
  endfunction

  // Sends one word after an optional idle gap. Start stays high between
  // back-to-back words, so it is only lowered when a gap is wanted. The
  // prediction is queued at the edge that accepts the word.
  task automatic send_word(input logic [OPCODE_W-1:0] op,
                           input logic signed [VALUE_W-1:0] val,
                           input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    opcode <= op;
    value  <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_deque_op(op, val));
  endtask

  // Holds off the sender until every predicted result has arrived, then
  // lets the pipeline settle.
  task automatic wait_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Pops from an empty queue must report underflow and leave it empty.
  task automatic test_pop_on_empty();
    send_word(OP_POP_FRONT, 32'sh1234_5678, 0);
    send_word(OP_POP_REAR, -32'sd1, 1);
    wait_until_drained();
  endtask

  // A front push into an empty queue is both front and rear; the pop that
  // empties it again must bring both value ports back to zero.
  task automatic test_front_push_on_empty();
    send_word(OP_PUSH_FRONT, 32'sh0bad_cafe, 0);
    send_word(OP_POP_REAR, '0, 0);
    send_word(OP_PUSH_FRONT, -32'sd77, 2);
    send_word(OP_POP_FRONT, '0, 0);
    wait_until_drained();
  endtask

  // Fills the queue from both ends, starting with the value extremes, then
  // pushes at each end while full and takes one word off each end.
  task automatic test_fill_to_overflow();
    send_word(OP_PUSH_REAR, 32'sh7fff_ffff, 0);
    send_word(OP_PUSH_FRONT, 32'sh8000_0000, 0);
    send_word(OP_PUSH_REAR, '0, 0);
    send_word(OP_PUSH_FRONT, -32'sd1, 0);
    for (int i = 4; i < RING_DEPTH; i++) begin
      send_word((i % 2 == 0) ? OP_PUSH_REAR : OP_PUSH_FRONT, pick_value(), pick_gap());
    end
    send_word(OP_PUSH_REAR, 32'sh5555_5555, 0);
    send_word(OP_PUSH_FRONT, 32'shaaaa_aaaa, 0);
    send_word(OP_POP_FRONT, '0, 0);
    send_word(OP_POP_REAR, '0, 0);
    wait_until_drained();
  endtask

  // Bursts that lean toward pushes, pops or neither, so the queue keeps
  // swinging between empty and full. Some bursts run with no idle cycles.
  task automatic test_random_traffic(input int word_total);
    int                  sent;
    int                  burst_len;
    int                  push_pct;
    bit                  no_idle;
    logic [OPCODE_W-1:0] op;
    sent = 0;
    while (sent < word_total) begin
      burst_len = $urandom_range(8, 64);
      case ($urandom_range(0, 2))
        0: push_pct = 85;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (burst_len) begin
        if ($urandom_range(0, 99) < push_pct) begin
          op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
        end else begin
          op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
        end
        send_word(op, pick_value(), no_idle ? 0 : pick_gap());
        sent++;
      end
      if ($urandom_range(0, 9) == 0) wait_until_drained();
    end
  endtask

  // Reports one field when it differs from its prediction. X or Z on the
  // actual port counts as a mismatch.
  task automatic compare_field(input string field_name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h",
               $time, field_name, exp_val, act_val);
      mismatch_count = mismatch_count + 1;
    end
  endtask

  // Results are sampled at the edge that ends the done cycle. The block
  // drives its ports from registers, so the values read here are the ones
  // that were stable during that cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing predicted, expected none, actual status %0d count %0d",
                 $time, status, entry_count);
        mismatch_count = mismatch_count + 1;
      end else begin
        oldest_result = pending_results.pop_front();
        compare_field("status", oldest_result.status, status);
        compare_field("is_empty", oldest_result.is_empty, is_empty);
        compare_field("entry_count", oldest_result.entry_count, entry_count);
        compare_field("front_value", oldest_result.front_value, front_value);
        compare_field("rear_value", oldest_result.rear_value, rear_value);
      end
    end
  end

  // The test sequence. Reset is held at the start and released once.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pop_on_empty();
    test_front_push_on_empty();
    test_fill_to_overflow();
    test_random_traffic(RANDOM_WORDS);
    wait_until_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog. A correct run takes well under a tenth of this time.
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bdq_pkg.sv
hdl/bdq_ctrl.sv
hdl/bdq_datapath.sv
hdl/bounded_double_ended_queue.sv
dv/tb_top.sv
